>>> hdl/ppp_pkg.sv
// shared types, constants and register codes of the pupil position projector
package ppp_pkg;

   // register indexes
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_RIM_WIDTH    = 3'd2;
   localparam logic [2:0] CSR_IRIS_WIDTH   = 3'd3;
   localparam logic [2:0] CSR_IRIS_HEIGHT  = 3'd4;

   // register reset values
   localparam logic [9:0] RST_FRAME_WIDTH  = 10'd64;
   localparam logic [9:0] RST_FRAME_HEIGHT = 10'd64;
   localparam logic [9:0] RST_RIM_WIDTH    = 10'd8;
   localparam logic [9:0] RST_IRIS_WIDTH   = 10'd16;
   localparam logic [9:0] RST_IRIS_HEIGHT  = 10'd16;

   // alignment codes, anything else acts as start
   localparam logic [1:0] ALIGN_CENTER = 2'd1;
   localparam logic [1:0] ALIGN_END    = 2'd2;

   // datapath widths
   localparam int ROOT_BITS = 13;  // quotient bits resolved, one per step stage
   localparam int Q_W       = 60;  // radicand
   localparam int A_W       = 40;  // numerator magnitude
   localparam int R_W       = 80;  // numerator squared, residual
   localparam int P_W       = 73;  // radicand times partial quotient
   localparam int D_W       = 90;  // step subtrahend
   localparam int C_W       = 9;   // frame center

   // pipeline depth: five front stages, root steps, output stage
   localparam int FRONT_STAGES = 5;
   localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_BITS + 1;

   typedef struct packed {
      logic signed [15:0] pointer_x;
      logic signed [15:0] pointer_y;
      logic signed [15:0] widget_x;
      logic signed [15:0] widget_y;
      logic [11:0]        widget_width;
      logic [11:0]        widget_height;
      logic [1:0]         horizontal_align;
      logic [1:0]         vertical_align;
   } req_type;

   typedef struct packed {
      logic signed [11:0] pupil_x;
      logic signed [11:0] pupil_y;
   } rsp_type;

   typedef struct packed {
      logic [9:0] frame_width;
      logic [9:0] frame_height;
      logic [9:0] rim_width;
      logic [9:0] iris_width;
      logic [9:0] iris_height;
   } cfg_type;

   // one lane of the root search
   typedef struct packed {
      logic [R_W-1:0]       r;    // numerator squared minus 4 f^2 q
      logic [P_W-1:0]       p;    // q times f
      logic [ROOT_BITS-1:0] f;    // quotient so far
      logic                 neg;  // offset is negative
   } lane_type;

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic           qz;
      logic [C_W-1:0] cx;
      logic [C_W-1:0] cy;
      lane_type       lx;
      lane_type       ly;
   } step_type;

endpackage

>>> hdl/pupil_position_projector.sv
// top level of the pupil position projector
//
//   channel  | ports                          | direction
//   ---------+--------------------------------+----------
//   request  | req_valid req_ready req_data   | in
//   response | rsp_valid rsp_ready rsp_data   | out
//   config   | csr_we csr_index csr_wdata     | in
//
// one item per cycle while rsp_ready does not hold the flow: five front stages,
// thirteen square-root division steps (one quotient bit each), one output stage
// each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stall at rsp_ready backs up without loss
// synchronous reset clears all valid bits and loads register reset values
module pupil_position_projector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ppp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppp_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [9:0]        csr_wdata
);

   localparam int N = ppp_pkg::PIPE_STAGES;
   localparam int F = ppp_pkg::FRONT_STAGES;
   localparam int B = ppp_pkg::ROOT_BITS;

   ppp_pkg::cfg_type  cfg_ff;
   logic [N-1:0]      vld_ff, vld_in;
   logic [N-1:0]      en;
   ppp_pkg::step_type stg [0:B];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= ppp_pkg::RST_FRAME_WIDTH;
         cfg_ff.frame_height <= ppp_pkg::RST_FRAME_HEIGHT;
         cfg_ff.rim_width    <= ppp_pkg::RST_RIM_WIDTH;
         cfg_ff.iris_width   <= ppp_pkg::RST_IRIS_WIDTH;
         cfg_ff.iris_height  <= ppp_pkg::RST_IRIS_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            ppp_pkg::CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_wdata;
            ppp_pkg::CSR_FRAME_HEIGHT: cfg_ff.frame_height <= csr_wdata;
            ppp_pkg::CSR_RIM_WIDTH:    cfg_ff.rim_width    <= csr_wdata;
            ppp_pkg::CSR_IRIS_WIDTH:   cfg_ff.iris_width   <= csr_wdata;
            ppp_pkg::CSR_IRIS_HEIGHT:  cfg_ff.iris_height  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage advance chain and valid bits
   always_comb begin
      en[N-1] = !vld_ff[N-1] || rsp_ready;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < N; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[N-1];

   // geometry and squared terms
   ppp_front u_front (
      .clock    (clock),
      .en       (en[F-1:0]),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .step_out (stg[0])
   );

   // quotient bits, most significant first
   for (genvar g = 0; g < B; g++) begin : g_root
      ppp_root_step #(
         .K (B - 1 - g)
      ) u_step (
         .clock    (clock),
         .en       (en[F+g]),
         .step_in  (stg[g]),
         .step_out (stg[g+1])
      );
   end

   // final rounding and output register
   ppp_back u_back (
      .clock    (clock),
      .en       (en[N-1]),
      .step_in  (stg[B]),
      .rsp_data (rsp_data)
   );

   // a free output never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input blocked while output is free");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an item leaving the last root step shows up as a result
   a_last_move: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[N-2] && en[N-1]) |=> rsp_valid)
      else $error("item lost entering the output stage");

endmodule

>>> hdl/ppp_front.sv
// front stages: offsets, radii, radicand and squared numerators
module ppp_front (
   input  logic                                 clock,
   input  logic [ppp_pkg::FRONT_STAGES-1:0]     en,
   input  ppp_pkg::req_type                     req_data,
   input  ppp_pkg::cfg_type                     cfg,
   output ppp_pkg::step_type                    step_out
);

   // stage 1 inputs
   logic [11:0]        freex_w, freey_w;
   logic [12:0]        termx_w, termy_w;
   logic signed [19:0] nx_in, ny_in;
   logic signed [11:0] rx_in, ry_in;
   logic signed [19:0] nx_ff, ny_ff;
   logic signed [11:0] rx_ff, ry_ff;
   logic [8:0]         cx1_ff, cy1_ff;

   // stage 2
   logic [19:0]        nxm_w, nym_w;
   logic [11:0]        rxm_w, rym_w;
   logic [17:0]        anx_w, any_w;
   logic [10:0]        arx_w, ary_w;
   logic [28:0]        m1_ff, m2_ff, m4_ff;
   logic [21:0]        m3_ff;
   logic [35:0]        sqnx_ff, sqny_ff;
   logic [21:0]        sqrx_ff;
   logic [10:0]        arx2_ff, ary2_ff;
   logic               snx2_ff, sny2_ff, srx2_ff, ryz2_ff;
   logic [8:0]         cx2_ff, cy2_ff;

   // stage 3
   logic [57:0]        m1sq_ff, m2sq_ff;
   logic [43:0]        m3sq_ff;
   logic [39:0]        ax3_ff, ay3_ff;
   logic [28:0]        m43_ff;
   logic [37:0]        s3_ff;
   logic               negx3_ff, negy3_ff, ryz3_ff;
   logic [8:0]         cx3_ff, cy3_ff;

   // stage 4
   logic [ppp_pkg::A_W-1:0] ax_w, ay_w;
   logic [ppp_pkg::Q_W-1:0] q_w;
   logic [ppp_pkg::Q_W-1:0] q4_ff;
   logic [39:0]        hhx_ff, hlx_ff, llx_ff, hhy_ff, hly_ff, lly_ff;
   logic               negx4_ff, negy4_ff;
   logic [8:0]         cx4_ff, cy4_ff;

   // stage 5
   ppp_pkg::step_type  step_in, step_ff;

   // stage 1: pointer relative to eye center, radii
   always_comb begin
      freex_w = (req_data.widget_width > {2'b0, cfg.frame_width})
              ? req_data.widget_width - {2'b0, cfg.frame_width} : 12'd0;
      freey_w = (req_data.widget_height > {2'b0, cfg.frame_height})
              ? req_data.widget_height - {2'b0, cfg.frame_height} : 12'd0;
      case (req_data.horizontal_align)
         ppp_pkg::ALIGN_CENTER: termx_w = {1'b0, freex_w};
         ppp_pkg::ALIGN_END:    termx_w = {freex_w, 1'b0};
         default:               termx_w = 13'd0;
      endcase
      case (req_data.vertical_align)
         ppp_pkg::ALIGN_CENTER: termy_w = {1'b0, freey_w};
         ppp_pkg::ALIGN_END:    termy_w = {freey_w, 1'b0};
         default:               termy_w = 13'd0;
      endcase
      nx_in = $signed({{3{req_data.pointer_x[15]}}, req_data.pointer_x, 1'b0})
            - $signed({7'b0, termx_w})
            - $signed({10'b0, cfg.frame_width[9:1], 1'b0})
            - $signed({{3{req_data.widget_x[15]}}, req_data.widget_x, 1'b0});
      ny_in = $signed({{3{req_data.pointer_y[15]}}, req_data.pointer_y, 1'b0})
            - $signed({7'b0, termy_w})
            - $signed({10'b0, cfg.frame_height[9:1], 1'b0})
            - $signed({{3{req_data.widget_y[15]}}, req_data.widget_y, 1'b0});
      rx_in = $signed({2'b0, cfg.frame_width}) - $signed({2'b0, cfg.rim_width})
            - $signed({2'b0, cfg.iris_width});
      ry_in = $signed({2'b0, cfg.frame_height}) - $signed({2'b0, cfg.rim_width})
            - $signed({2'b0, cfg.iris_height});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         cx1_ff <= cfg.frame_width[9:1];
         cy1_ff <= cfg.frame_height[9:1];
      end
   end

   // stage 2: magnitudes and first products
   always_comb begin
      nxm_w = nx_ff[19] ? 20'(-nx_ff) : 20'(nx_ff);
      nym_w = ny_ff[19] ? 20'(-ny_ff) : 20'(ny_ff);
      rxm_w = rx_ff[11] ? 12'(-rx_ff) : 12'(rx_ff);
      rym_w = ry_ff[11] ? 12'(-ry_ff) : 12'(ry_ff);
      anx_w = nxm_w[17:0];
      any_w = nym_w[17:0];
      arx_w = rxm_w[10:0];
      ary_w = rym_w[10:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         m1_ff   <= 29'(anx_w) * 29'(ary_w);
         m2_ff   <= 29'(any_w) * 29'(arx_w);
         m3_ff   <= 22'(arx_w) * 22'(ary_w);
         m4_ff   <= 29'(anx_w) * 29'(arx_w);
         sqnx_ff <= 36'(anx_w) * 36'(anx_w);
         sqny_ff <= 36'(any_w) * 36'(any_w);
         sqrx_ff <= 22'(arx_w) * 22'(arx_w);
         arx2_ff <= arx_w;
         ary2_ff <= ary_w;
         snx2_ff <= nx_ff[19];
         sny2_ff <= ny_ff[19];
         srx2_ff <= rx_ff[11];
         ryz2_ff <= (ry_ff == 12'sd0);
         cx2_ff  <= cx1_ff;
         cy2_ff  <= cy1_ff;
      end
   end

   // stage 3: squares of the scaled offsets, numerators, flat-eye radicand
   always_ff @(posedge clock) begin
      if (en[2]) begin
         m1sq_ff  <= 58'(m1_ff) * 58'(m1_ff);
         m2sq_ff  <= 58'(m2_ff) * 58'(m2_ff);
         m3sq_ff  <= 44'(m3_ff) * 44'(m3_ff);
         ax3_ff   <= 40'(m1_ff) * 40'(arx2_ff);
         ay3_ff   <= 40'(m2_ff) * 40'(ary2_ff);
         m43_ff   <= m4_ff;
         s3_ff    <= 38'(sqnx_ff) + 38'(sqny_ff) + 38'({sqrx_ff, 3'b0}) + 38'(sqrx_ff);
         negx3_ff <= srx2_ff ^ snx2_ff;
         negy3_ff <= srx2_ff ^ sny2_ff;
         ryz3_ff  <= ryz2_ff;
         cx3_ff   <= cx2_ff;
         cy3_ff   <= cy2_ff;
      end
   end

   // stage 4: radicand select, numerator squared in partial products
   always_comb begin
      q_w  = ryz3_ff ? ppp_pkg::Q_W'(s3_ff)
                     : ppp_pkg::Q_W'(m1sq_ff) + ppp_pkg::Q_W'(m2sq_ff)
                       + ppp_pkg::Q_W'({m3sq_ff, 3'b0}) + ppp_pkg::Q_W'(m3sq_ff);
      ax_w = ryz3_ff ? ppp_pkg::A_W'(m43_ff) : ax3_ff;
      ay_w = ryz3_ff ? '0 : ay3_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         q4_ff    <= q_w;
         hhx_ff   <= 40'(ax_w[39:20]) * 40'(ax_w[39:20]);
         hlx_ff   <= 40'(ax_w[39:20]) * 40'(ax_w[19:0]);
         llx_ff   <= 40'(ax_w[19:0]) * 40'(ax_w[19:0]);
         hhy_ff   <= 40'(ay_w[39:20]) * 40'(ay_w[39:20]);
         hly_ff   <= 40'(ay_w[39:20]) * 40'(ay_w[19:0]);
         lly_ff   <= 40'(ay_w[19:0]) * 40'(ay_w[19:0]);
         negx4_ff <= negx3_ff;
         negy4_ff <= negy3_ff;
         cx4_ff   <= cx3_ff;
         cy4_ff   <= cy3_ff;
      end
   end

   // stage 5: assemble squared numerators, seed the root search
   always_comb begin
      step_in.q     = q4_ff;
      step_in.qz    = (q4_ff == '0);
      step_in.cx    = cx4_ff;
      step_in.cy    = cy4_ff;
      step_in.lx.r  = (ppp_pkg::R_W'(hhx_ff) << 40) + (ppp_pkg::R_W'(hlx_ff) << 21)
                    + ppp_pkg::R_W'(llx_ff);
      step_in.lx.p  = '0;
      step_in.lx.f  = '0;
      step_in.lx.neg = negx4_ff;
      step_in.ly.r  = (ppp_pkg::R_W'(hhy_ff) << 40) + (ppp_pkg::R_W'(hly_ff) << 21)
                    + ppp_pkg::R_W'(lly_ff);
      step_in.ly.p  = '0;
      step_in.ly.f  = '0;
      step_in.ly.neg = negy4_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         step_ff <= step_in;
      end
   end

   assign step_out = step_ff;

endmodule

>>> hdl/ppp_root_step.sv
// one quotient bit of the square-root division, both lanes
module ppp_root_step #(
   parameter int K = 0
) (
   input  logic              clock,
   input  logic              en,
   input  ppp_pkg::step_type step_in,
   output ppp_pkg::step_type step_out
);

   ppp_pkg::step_type step_ff, step_nx;

   // try bit K: 4 (f+b)^2 q - 4 f^2 q = (q f) << (K+3) + q << (2K+2)
   function automatic ppp_pkg::lane_type try_bit(ppp_pkg::lane_type l,
                                                  logic [ppp_pkg::Q_W-1:0] q);
      logic [ppp_pkg::D_W-1:0] d;
      ppp_pkg::lane_type       o;
      d = (ppp_pkg::D_W'(l.p) << (K + 3)) + (ppp_pkg::D_W'(q) << (2 * K + 2));
      o = l;
      if (d <= ppp_pkg::D_W'(l.r)) begin
         o.r    = l.r - ppp_pkg::R_W'(d);
         o.f[K] = 1'b1;
         o.p    = l.p + (ppp_pkg::P_W'(q) << K);
      end
      return o;
   endfunction

   // per-lane trial subtract
   always_comb begin
      step_nx    = step_in;
      step_nx.lx = try_bit(step_in.lx, step_in.q);
      step_nx.ly = try_bit(step_in.ly, step_in.q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_nx;
      end
   end

   assign step_out = step_ff;

endmodule

>>> hdl/ppp_back.sv
// output stage: truncation toward zero and frame center offset
module ppp_back (
   input  logic              clock,
   input  logic              en,
   input  ppp_pkg::step_type step_in,
   output ppp_pkg::rsp_type  rsp_data
);

   ppp_pkg::rsp_type rsp_ff, rsp_in;

   // center plus offset, truncated toward zero
   function automatic logic [11:0] place(ppp_pkg::lane_type l,
                                         logic [ppp_pkg::C_W-1:0] c, logic qz);
      logic signed [15:0] cs, mag, fs, fl, ce, pick, res;
      cs   = $signed({7'b0, c});
      fs   = $signed({3'b0, l.f});
      mag  = fs + $signed({15'b0, (l.r != '0)});
      fl   = l.neg ? -mag : fs;
      ce   = l.neg ? -fs : mag;
      pick = (fl >= -cs) ? fl : ce;
      res  = qz ? cs : cs + pick;
      return res[11:0];
   endfunction

   always_comb begin
      rsp_in.pupil_x = place(step_in.lx, step_in.cx, step_in.qz);
      rsp_in.pupil_y = place(step_in.ly, step_in.cy, step_in.qz);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> bench/tb.sv
// testbench of the pupil position projector: scoreboard, stimulus and checks
`timescale 1ns / 1ps

module tb;

   // expected pupil positions and the register copy they are computed from
   class pupil_scoreboard;
      ppp_pkg::cfg_type cfg;
      ppp_pkg::rsp_type pupil_queue[$];
      int      errors;
      int      checked;

      function new();
         cfg = '{ppp_pkg::RST_FRAME_WIDTH, ppp_pkg::RST_FRAME_HEIGHT,
                 ppp_pkg::RST_RIM_WIDTH, ppp_pkg::RST_IRIS_WIDTH,
                 ppp_pkg::RST_IRIS_HEIGHT};
         errors = 0;
         checked = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [9:0] val);
         case (idx)
            ppp_pkg::CSR_FRAME_WIDTH:  cfg.frame_width = val;
            ppp_pkg::CSR_FRAME_HEIGHT: cfg.frame_height = val;
            ppp_pkg::CSR_RIM_WIDTH:    cfg.rim_width = val;
            ppp_pkg::CSR_IRIS_WIDTH:   cfg.iris_width = val;
            ppp_pkg::CSR_IRIS_HEIGHT:  cfg.iris_height = val;
            default: ;
         endcase
      endfunction

      // true when 4 k^2 q <= a^2
      function bit root_fits(logic [127:0] k, logic [127:0] q, logic [127:0] a,
                             output bit same);
         logic [127:0] lhs;
         logic [127:0] rhs;
         lhs = 4 * k * k * q;
         rhs = a * a;
         same = (lhs == rhs);
         return lhs <= rhs;
      endfunction

      // trunc(c + num / (2 sqrt q)), bit by bit search of the quotient
      function longint offset_trunc(longint c, longint num, logic [127:0] q);
         logic [127:0] mag;
         logic [127:0] f;
         logic [127:0] b;
         bit           same;
         bit           exact;
         longint       fl;
         longint       ce;
         if (q == 0) return c;
         mag = (num < 0) ? -num : num;
         f = 0;
         for (int i = 12; i >= 0; i--) begin
            b = 128'd1 << i;
            if (root_fits(f | b, q, mag, same)) f = f | b;
         end
         void'(root_fits(f, q, mag, exact));
         if (num >= 0) begin
            fl = longint'(f);
            ce = longint'(f) + (exact ? 0 : 1);
         end else begin
            fl = -(longint'(f) + (exact ? 0 : 1));
            ce = -longint'(f);
         end
         return (fl >= -c) ? c + fl : c + ce;
      endfunction

      function longint align_mult(logic [1:0] code);
         if (code == ppp_pkg::ALIGN_CENTER) return 1;
         if (code == ppp_pkg::ALIGN_END) return 2;
         return 0;
      endfunction

      function ppp_pkg::rsp_type pupil_of(ppp_pkg::req_type r);
         longint fw, fh, cx, cy, fx, fy, nx, ny, rx, ry, arx, ary, ox, oy;
         logic [127:0] anx, any, urx, ury, q;
         ppp_pkg::rsp_type p;
         fw = cfg.frame_width;
         fh = cfg.frame_height;
         cx = fw / 2;
         cy = fh / 2;
         fx = (longint'(r.widget_width) > fw) ? longint'(r.widget_width) - fw : 0;
         fy = (longint'(r.widget_height) > fh) ? longint'(r.widget_height) - fh : 0;
         nx = 2 * longint'(r.pointer_x) - fx * align_mult(r.horizontal_align)
              - 2 * cx - 2 * longint'(r.widget_x);
         ny = 2 * longint'(r.pointer_y) - fy * align_mult(r.vertical_align)
              - 2 * cy - 2 * longint'(r.widget_y);
         rx = fw - longint'(cfg.rim_width) - longint'(cfg.iris_width);
         ry = fh - longint'(cfg.rim_width) - longint'(cfg.iris_height);
         arx = (rx < 0) ? -rx : rx;
         ary = (ry < 0) ? -ry : ry;
         anx = (nx < 0) ? -nx : nx;
         any = (ny < 0) ? -ny : ny;
         urx = arx;
         ury = ary;
         if (ry != 0) begin
            q = anx * anx * ury * ury + any * any * urx * urx + 9 * urx * urx * ury * ury;
            ox = offset_trunc(cx, rx * nx * ary, q);
            oy = offset_trunc(cy, rx * ny * ary, q);
         end else begin
            q = anx * anx + any * any + 9 * urx * urx;
            ox = offset_trunc(cx, rx * nx, q);
            oy = cy;
         end
         p.pupil_x = ox[11:0];
         p.pupil_y = oy[11:0];
         return p;
      endfunction

      function void note(ppp_pkg::req_type r);
         pupil_queue.push_back(pupil_of(r));
      endfunction

      task report(string what, int got, int want);
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  checked, what, got, want);
         errors++;
      endtask

      task check(ppp_pkg::rsp_type got);
         ppp_pkg::rsp_type want;
         if (pupil_queue.size() == 0) begin
            report("unexpected result, pupil_x", got.pupil_x, 0);
         end else begin
            want = pupil_queue.pop_front();
            if (got.pupil_x !== want.pupil_x) report("pupil_x", got.pupil_x, want.pupil_x);
            if (got.pupil_y !== want.pupil_y) report("pupil_y", got.pupil_y, want.pupil_y);
         end
         checked++;
      endtask

      function int pending();
         return pupil_queue.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   ppp_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   ppp_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [2:0]       csr_index;
   logic [9:0]       csr_wdata;

   pupil_scoreboard sb;
   int cycles;
   int hold_asked;
   int hold_done;
   int hold_left;
   int stall_mode;

   pupil_position_projector i_dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);
   end

   // receiver stalls: random ready patterns, long hold-off on request
   always @(negedge clock) begin
      if (cycles % 64 == 0) stall_mode <= int'($urandom_range(0, 3));
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         hold_done <= hold_asked;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) != 0);
            2: rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // offer one item and wait until it is taken
   task send_item(ppp_pkg::req_type d);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (!req_ready);
      sb.note(d);
   endtask

   task sender_gap(int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task drain();
      sender_gap(1);
      while (sb.pending() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [9:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task load_frame(logic [9:0] fw, logic [9:0] fh, logic [9:0] rim,
                   logic [9:0] iw, logic [9:0] ih);
      write_reg(ppp_pkg::CSR_FRAME_WIDTH, fw);
      write_reg(ppp_pkg::CSR_FRAME_HEIGHT, fh);
      write_reg(ppp_pkg::CSR_RIM_WIDTH, rim);
      write_reg(ppp_pkg::CSR_IRIS_WIDTH, iw);
      write_reg(ppp_pkg::CSR_IRIS_HEIGHT, ih);
   endtask

   function ppp_pkg::req_type pointer_item(int px, int py, int wx, int wy, int ww,
                                           int wh, int ha, int va);
      ppp_pkg::req_type r;
      r.pointer_x = 16'(px);
      r.pointer_y = 16'(py);
      r.widget_x = 16'(wx);
      r.widget_y = 16'(wy);
      r.widget_width = 12'(ww);
      r.widget_height = 12'(wh);
      r.horizontal_align = 2'(ha);
      r.vertical_align = 2'(va);
      return r;
   endfunction

   // mostly pointers near the widget, some anywhere
   function ppp_pkg::req_type random_item();
      ppp_pkg::req_type r;
      logic [95:0]      raw;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(ppp_pkg::req_type)-1:0];
      if ($urandom_range(0, 9) < 7) begin
         r.widget_x = 16'($signed($urandom_range(0, 2000)) - 1000);
         r.widget_y = 16'($signed($urandom_range(0, 2000)) - 1000);
         r.pointer_x = 16'(r.widget_x + $signed($urandom_range(0, 1600)) - 400);
         r.pointer_y = 16'(r.widget_y + $signed($urandom_range(0, 1600)) - 400);
         if ($urandom_range(0, 1) != 0) r.widget_width = 12'($urandom_range(0, 1500));
         if ($urandom_range(0, 1) != 0) r.widget_height = 12'($urandom_range(0, 1500));
      end
      return r;
   endfunction

   // bursts with random gaps, sometimes back to back
   task random_burst(int count);
      int left;
      int len;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 20);
         for (int i = 0; i < len && left > 0; i++) begin
            send_item(random_item());
            left--;
         end
         if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 6));
      end
   endtask

   initial begin
      sb = new();
      cycles = 0;
      hold_asked = 0;
      hold_done = 0;
      hold_left = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes and every alignment code at reset settings
      send_item(pointer_item(0, 0, 0, 0, 0, 0, 0, 0));
      send_item(pointer_item(32, 32, 0, 0, 64, 64, 0, 0));
      send_item(pointer_item(32767, 32767, -32768, -32768, 4095, 4095, 2, 2));
      send_item(pointer_item(-32768, -32768, 32767, 32767, 4095, 4095, 2, 2));
      send_item(pointer_item(-32768, 32767, 32767, -32768, 0, 4095, 1, 3));
      send_item(pointer_item(100, -100, 10, 10, 300, 300, 1, 1));
      send_item(pointer_item(100, -100, 10, 10, 300, 300, 2, 0));
      send_item(pointer_item(100, -100, 10, 10, 300, 300, 3, 3));
      send_item(pointer_item(500, 20, 0, 0, 64, 64, 0, 0));
      send_item(pointer_item(20, 500, 0, 0, 64, 64, 0, 0));
      send_item(pointer_item(-1, -1, 0, 0, 63, 65, 1, 2));
      drain();

      // zero root: degenerate frame, with the pointer at the center and off it
      load_frame(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      send_item(pointer_item(0, 0, 0, 0, 0, 0, 0, 0));
      send_item(pointer_item(-500, 77, -500, 77, 0, 0, 3, 3));
      send_item(pointer_item(5, 7, 0, 0, 0, 0, 0, 0));
      random_burst(60);
      drain();

      // zero vertical radius, including zero root there
      load_frame(10'd100, 10'd40, 10'd10, 10'd50, 10'd30);
      send_item(pointer_item(50, 20, 0, 0, 0, 0, 0, 0));
      send_item(pointer_item(2000, -9, 0, 0, 0, 0, 0, 0));
      random_burst(80);
      drain();
      load_frame(10'd60, 10'd40, 10'd20, 10'd40, 10'd20);
      send_item(pointer_item(30, 20, 0, 0, 0, 0, 0, 0));
      random_burst(60);
      drain();

      // largest frame, no rim or iris; long receiver hold-off fills the pipe
      load_frame(10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0);
      hold_asked = hold_asked + 1;
      for (int i = 0; i < 80; i++) send_item(random_item());
      random_burst(40);
      drain();

      // negative radii, largest subtrahends
      load_frame(10'd20, 10'd30, 10'd1023, 10'd1023, 10'd1023);
      random_burst(80);
      drain();
      load_frame(10'd1023, 10'd1, 10'd1023, 10'd0, 10'd1023);
      random_burst(80);
      drain();

      // back to reset values, sender pause in the middle
      load_frame(ppp_pkg::RST_FRAME_WIDTH, ppp_pkg::RST_FRAME_HEIGHT,
                 ppp_pkg::RST_RIM_WIDTH, ppp_pkg::RST_IRIS_WIDTH,
                 ppp_pkg::RST_IRIS_HEIGHT);
      random_burst(50);
      sender_gap(1);
      while (sb.pending() != 0) @(negedge clock);
      random_burst(50);
      drain();

      // random settings
      for (int p = 0; p < 4; p++) begin
         load_frame(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                    10'($urandom_range(0, 300)), 10'($urandom_range(0, 300)),
                    10'($urandom_range(0, 300)));
         random_burst(70);
         drain();
      end

      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/ppp_pkg.sv
hdl/ppp_front.sv
hdl/ppp_root_step.sv
hdl/ppp_back.sv
hdl/pupil_position_projector.sv
bench/tb.sv
